/* hw/rtl/dscc_pkg.sv */
`default_nettype none

package dscc_pkg;

  localparam int unsigned DEF_MAX_NODES        = 64;
  localparam int unsigned DEF_EDGE_COUNT_WIDTH = 4;
  localparam int unsigned NODE_FIELD_W         = 7;
  localparam int unsigned TOTAL_W              = 32;
  localparam int unsigned APB_ADDR_W           = 3;
  localparam int unsigned APB_DATA_W           = 32;

  // register index (paddr[2])
  localparam logic REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_SAT    = 2'd2,
    ST_ABSENT = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_EDGE_RD,
    S_EDGE_WR,
    S_QA,
    S_QB,
    S_QC,
    S_CLR,
    S_ROOT,
    S_ROOT_CHK,
    S_ENTER,
    S_SCAN,
    S_EVAL,
    S_POP,
    S_CPOP,
    S_CPOP_D,
    S_RET,
    S_RET_D,
    S_RET_L,
    S_RESP
  } state_e;

  typedef struct packed {
    logic [1:0]              operation;
    logic [NODE_FIELD_W-1:0] from_node;
    logic [NODE_FIELD_W-1:0] to_node;
  } in_t;

  typedef struct packed {
    logic               same_component;
    logic               is_answer;
    logic [1:0]         status;
    logic [TOTAL_W-1:0] yes_count;
    logic [TOTAL_W-1:0] no_count;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/dscc_ram.sv */
`default_nettype none

module dscc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* hw/rtl/dscc_cfg.sv */
`default_nettype none

module dscc_cfg
  import dscc_pkg::*;
#(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES,
  localparam int unsigned DW = $clog2(MAX_NODES + 1)
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output logic      [DW-1:0]         n_o
);

  logic [NODE_FIELD_W-1:0] node_count_q;
  // set until the first write: node count then reads as MAX_NODES
  logic                    dflt_q;
  logic                    wr;
  logic [NODE_FIELD_W-1:0] rd_val;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
      dflt_q       <= 1'b1;
    end else if (wr) begin
      node_count_q <= pwdata[NODE_FIELD_W-1:0];
      dflt_q       <= 1'b0;
    end
  end

  always_comb begin
    if (dflt_q || (32'(node_count_q) > 32'(MAX_NODES))) begin
      n_o = DW'(MAX_NODES);
    end else begin
      n_o = DW'(node_count_q);
    end
  end

  assign rd_val = dflt_q ? NODE_FIELD_W'(MAX_NODES) : node_count_q;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ?
                  APB_DATA_W'(rd_val) : '0;

endmodule

`default_nettype wire

/* hw/rtl/dscc_engine.sv */
`default_nettype none

module dscc_engine
  import dscc_pkg::*;
#(
  parameter int unsigned MAX_NODES        = DEF_MAX_NODES,
  parameter int unsigned EDGE_COUNT_WIDTH = DEF_EDGE_COUNT_WIDTH,
  localparam int unsigned DW = $clog2(MAX_NODES + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [DW-1:0] n_i,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire in_t           in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output out_t               out_data_o
);

  localparam int unsigned NW    = $clog2(MAX_NODES);
  localparam int unsigned EDEPTH = MAX_NODES * MAX_NODES;
  localparam int unsigned AW    = $clog2(EDEPTH);
  localparam int unsigned ECW   = EDGE_COUNT_WIDTH;
  localparam int unsigned FW    = NW + DW;

  function automatic logic [AW-1:0] eaddr(input logic [NW-1:0] u, input logic [NW-1:0] w);
    return AW'(32'(u) * 32'(MAX_NODES) + 32'(w));
  endfunction

  state_e state_q, state_d;

  logic [1:0]         op_q, op_d;
  logic [NW-1:0]      a_q, a_d, b_q, b_d;
  logic [1:0]         status_q, status_d;
  logic               same_q, same_d, ans_q, ans_d;
  logic [TOTAL_W-1:0] yes_q, yes_d, no_q, no_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [AW-1:0]      clr_q, clr_d;
  logic [NW-1:0]      i_q, i_d;
  logic [DW-1:0]      vc_q, vc_d, r_q, r_d, csp_q, csp_d, sp_q, sp_d;
  logic [NW-1:0]      cur_u_q, cur_u_d, nv_q, nv_d, lab_a_q, lab_a_d;
  logic [DW-1:0]      cur_w_q, cur_w_d, cur_disc_q, cur_disc_d, cur_low_q, cur_low_d;
  logic               has_cur_q, has_cur_d;

  // memory ports
  logic            e_we;
  logic [AW-1:0]   e_waddr, e_raddr;
  logic [ECW-1:0]  e_wdata, e_rdata;
  logic            l_we;
  logic [NW-1:0]   l_waddr, l_raddr, l_wdata, l_rdata;
  logic            o_we;
  logic [NW-1:0]   o_waddr, o_raddr;
  logic            o_wdata, o_rdata;
  logic            d_we;
  logic [NW-1:0]   d_waddr, d_raddr;
  logic [2*DW-1:0] d_wdata, d_rdata;
  logic            c_we;
  logic [NW-1:0]   c_waddr, c_raddr;
  logic [FW-1:0]   c_wdata, c_rdata;
  logic            k_we;
  logic [NW-1:0]   k_waddr, k_raddr, k_wdata, k_rdata;

  logic          in_acc, bad;
  logic [DW-1:0] rd_disc, rd_low, vc_inc, new_low;
  logic [NW-1:0] w_idx;

  dscc_ram #(.WIDTH(ECW), .DEPTH(EDEPTH)) u_edge_ram (
    .clk_i, .we_i(e_we), .waddr_i(e_waddr), .wdata_i(e_wdata),
    .raddr_i(e_raddr), .rdata_o(e_rdata)
  );
  dscc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_label_ram (
    .clk_i, .we_i(l_we), .waddr_i(l_waddr), .wdata_i(l_wdata),
    .raddr_i(l_raddr), .rdata_o(l_rdata)
  );
  dscc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_onstk_ram (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .raddr_i(o_raddr), .rdata_o(o_rdata)
  );
  dscc_ram #(.WIDTH(2*DW), .DEPTH(MAX_NODES)) u_dl_ram (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .raddr_i(d_raddr), .rdata_o(d_rdata)
  );
  dscc_ram #(.WIDTH(FW), .DEPTH(MAX_NODES)) u_call_ram (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(c_wdata),
    .raddr_i(c_raddr), .rdata_o(c_rdata)
  );
  dscc_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_cstk_ram (
    .clk_i, .we_i(k_we), .waddr_i(k_waddr), .wdata_i(k_wdata),
    .raddr_i(k_raddr), .rdata_o(k_rdata)
  );

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign bad = (in_data_i.from_node == '0) || (in_data_i.to_node == '0) ||
               (32'(in_data_i.from_node) > 32'(n_i)) ||
               (32'(in_data_i.to_node) > 32'(n_i));

  assign rd_disc = d_rdata[2*DW-1:DW];
  assign rd_low  = d_rdata[DW-1:0];
  assign vc_inc  = vc_q + DW'(1);
  assign w_idx   = cur_w_q[NW-1:0];
  assign new_low = (cur_low_q < rd_low) ? cur_low_q : rd_low;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_INIT: begin
        if (32'(clr_q) == EDEPTH - 1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.operation != OP_INSERT && in_data_i.operation != OP_REMOVE &&
              in_data_i.operation != OP_QUERY) begin
            state_d = S_RESP;
          end else if (bad) begin
            state_d = S_RESP;
          end else if (in_data_i.operation == OP_QUERY) begin
            state_d = S_QA;
          end else begin
            state_d = S_EDGE_RD;
          end
        end
      end
      S_EDGE_RD:  state_d = S_EDGE_WR;
      S_EDGE_WR:  state_d = S_CLR;
      S_QA:       state_d = S_QB;
      S_QB:       state_d = S_QC;
      S_QC:       state_d = S_RESP;
      S_CLR: begin
        if (32'(i_q) == MAX_NODES - 1) state_d = S_ROOT;
      end
      S_ROOT:     state_d = (r_q >= n_i) ? S_RESP : S_ROOT_CHK;
      S_ROOT_CHK: state_d = (rd_disc != '0) ? S_ROOT : S_ENTER;
      S_ENTER:    state_d = S_SCAN;
      S_SCAN:     state_d = (cur_w_q < n_i) ? S_EVAL : S_POP;
      S_EVAL: begin
        if (e_rdata != '0 && rd_disc == '0) state_d = S_ENTER;
        else                                state_d = S_SCAN;
      end
      S_POP:      state_d = (cur_low_q == cur_disc_q) ? S_CPOP : S_RET;
      S_CPOP:     state_d = S_CPOP_D;
      S_CPOP_D: begin
        if (k_rdata != cur_u_q && csp_q != '0) state_d = S_CPOP;
        else                                   state_d = S_RET;
      end
      S_RET:      state_d = (sp_q == '0) ? S_ROOT : S_RET_D;
      S_RET_D:    state_d = S_RET_L;
      S_RET_L:    state_d = S_SCAN;
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      end
      default:    state_d = S_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    op_d = op_q; a_d = a_q; b_d = b_q; status_d = status_q;
    same_d = same_q; ans_d = ans_q; yes_d = yes_q; no_d = no_q;
    out_d = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    clr_d = clr_q; i_d = i_q; vc_d = vc_q; r_d = r_q; csp_d = csp_q; sp_d = sp_q;
    cur_u_d = cur_u_q; cur_w_d = cur_w_q; cur_disc_d = cur_disc_q;
    cur_low_d = cur_low_q; has_cur_d = has_cur_q; nv_d = nv_q; lab_a_d = lab_a_q;

    e_we = 1'b0; e_waddr = eaddr(a_q, b_q); e_wdata = '0; e_raddr = eaddr(a_q, b_q);
    l_we = 1'b0; l_waddr = i_q; l_wdata = i_q; l_raddr = a_q;
    o_we = 1'b0; o_waddr = i_q; o_wdata = 1'b0; o_raddr = w_idx;
    d_we = 1'b0; d_waddr = i_q; d_wdata = '0; d_raddr = w_idx;
    c_we = 1'b0; c_waddr = sp_q[NW-1:0]; c_wdata = {cur_u_q, cur_w_q};
    c_raddr = NW'(sp_q - DW'(1));
    k_we = 1'b0; k_waddr = csp_q[NW-1:0]; k_wdata = nv_q;
    k_raddr = NW'(csp_q - DW'(1));

    case (state_q)
      S_INIT: begin
        e_we    = 1'b1;
        e_waddr = clr_q;
        clr_d   = clr_q + AW'(1);
        if (32'(clr_q) < MAX_NODES) begin
          l_we = 1'b1; l_waddr = clr_q[NW-1:0]; l_wdata = clr_q[NW-1:0];
          o_we = 1'b1; o_waddr = clr_q[NW-1:0];
          d_we = 1'b1; d_waddr = clr_q[NW-1:0];
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d     = in_data_i.operation;
          a_d      = NW'(32'(in_data_i.from_node) - 32'd1);
          b_d      = NW'(32'(in_data_i.to_node) - 32'd1);
          same_d   = 1'b0;
          ans_d    = 1'b0;
          status_d = ST_OK;
          if ((in_data_i.operation == OP_INSERT || in_data_i.operation == OP_REMOVE ||
               in_data_i.operation == OP_QUERY) && bad) begin
            status_d = ST_RANGE;
          end
        end
      end
      S_EDGE_WR: begin
        i_d = '0;
        if (op_q == OP_INSERT) begin
          if (e_rdata == '1) begin
            status_d = ST_SAT;
          end else begin
            e_we = 1'b1; e_wdata = e_rdata + ECW'(1);
          end
        end else begin
          if (e_rdata == '0) begin
            status_d = ST_ABSENT;
          end else begin
            e_we = 1'b1; e_wdata = e_rdata - ECW'(1);
          end
        end
      end
      S_QB: begin
        l_raddr = b_q;
        lab_a_d = l_rdata;
      end
      S_QC: begin
        ans_d = 1'b1;
        if (lab_a_q == l_rdata) begin
          same_d = 1'b1;
          yes_d  = yes_q + TOTAL_W'(1);
        end else begin
          no_d = no_q + TOTAL_W'(1);
        end
      end
      S_CLR: begin
        l_we = 1'b1; o_we = 1'b1; d_we = 1'b1;
        i_d = i_q + NW'(1);
        vc_d = '0; r_d = '0; csp_d = '0; sp_d = '0; has_cur_d = 1'b0;
      end
      S_ROOT: begin
        d_raddr = r_q[NW-1:0];
      end
      S_ROOT_CHK: begin
        if (rd_disc != '0) r_d = r_q + DW'(1);
        else               nv_d = r_q[NW-1:0];
      end
      S_ENTER: begin
        vc_d = vc_inc;
        d_we = 1'b1; d_waddr = nv_q; d_wdata = {vc_inc, vc_inc};
        o_we = 1'b1; o_waddr = nv_q; o_wdata = 1'b1;
        k_we = 1'b1;
        csp_d = csp_q + DW'(1);
        if (has_cur_q) begin
          c_we = 1'b1;
          sp_d = sp_q + DW'(1);
        end
        cur_u_d = nv_q; cur_w_d = '0; cur_disc_d = vc_inc; cur_low_d = vc_inc;
        has_cur_d = 1'b1;
      end
      S_SCAN: begin
        e_raddr = eaddr(cur_u_q, w_idx);
      end
      S_EVAL: begin
        cur_w_d = cur_w_q + DW'(1);
        if (e_rdata != '0) begin
          if (rd_disc == '0) begin
            nv_d = w_idx;
          end else if (o_rdata && rd_disc < cur_low_q) begin
            cur_low_d = rd_disc;
            d_we = 1'b1; d_waddr = cur_u_q; d_wdata = {cur_disc_q, rd_disc};
          end
        end
      end
      S_CPOP: begin
        csp_d = csp_q - DW'(1);
      end
      S_CPOP_D: begin
        o_we = 1'b1; o_waddr = k_rdata; o_wdata = 1'b0;
        l_we = 1'b1; l_waddr = k_rdata; l_wdata = cur_u_q;
      end
      S_RET: begin
        if (sp_q == '0) begin
          has_cur_d = 1'b0;
          r_d = r_q + DW'(1);
        end else begin
          sp_d = sp_q - DW'(1);
        end
      end
      S_RET_D: begin
        cur_u_d = c_rdata[FW-1:DW];
        cur_w_d = c_rdata[DW-1:0];
        d_raddr = c_rdata[FW-1:DW];
      end
      S_RET_L: begin
        cur_disc_d = rd_disc;
        cur_low_d  = new_low;
        d_we = 1'b1; d_waddr = cur_u_q; d_wdata = {rd_disc, new_low};
      end
      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d          = 1'b1;
          out_d.same_component = same_q;
          out_d.is_answer      = ans_q;
          out_d.status         = status_q;
          out_d.yes_count      = yes_q;
          out_d.no_count       = no_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
      yes_q       <= '0;
      no_q        <= '0;
      vc_q        <= '0;
      r_q         <= '0;
      csp_q       <= '0;
      sp_q        <= '0;
      has_cur_q   <= 1'b0;
      i_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
      yes_q       <= yes_d;
      no_q        <= no_d;
      vc_q        <= vc_d;
      r_q         <= r_d;
      csp_q       <= csp_d;
      sp_q        <= sp_d;
      has_cur_q   <= has_cur_d;
      i_q         <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    a_q        <= a_d;
    b_q        <= b_d;
    status_q   <= status_d;
    same_q     <= same_d;
    ans_q      <= ans_d;
    out_q      <= out_d;
    cur_u_q    <= cur_u_d;
    cur_w_q    <= cur_w_d;
    cur_disc_q <= cur_disc_d;
    cur_low_q  <= cur_low_d;
    nv_q       <= nv_d;
    lab_a_q    <= lab_a_d;
  end

endmodule

`default_nettype wire

/* hw/rtl/dynamic_scc_membership.sv */
// Strongly connected component membership over a directed multigraph of up to
// MAX_NODES nodes, numbered from 1. Each transaction inserts an edge, removes
// one copy of an edge, or asks whether two nodes share a component; every
// transaction yields exactly one result transaction carrying a status and the
// running yes/no query totals. Edge counts live in a MAX_NODES x MAX_NODES
// memory; per-node discovery/low-link, on-stack flags, labels and the two DFS
// stacks live in small simple dual-port memories. After reset a clearing pass
// zeroes the edge memory; no transaction is taken during it, though node_count
// may be written. A query reads the labels of both nodes and compares them.
// An insert or remove that is in range reruns Tarjan's DFS: it first clears
// per-node state, then scans each (node, neighbor) pair in two steps (edge
// memory read, then evaluate). Out-of-range nodes go straight to the result.
// The next transaction is accepted once the result is in the output register,
// even while that result is still stalled.
`default_nettype none

module dynamic_scc_membership
  import dscc_pkg::*;
#(
  parameter int unsigned MAX_NODES        = DEF_MAX_NODES,
  parameter int unsigned EDGE_COUNT_WIDTH = DEF_EDGE_COUNT_WIDTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output out_t                       out_data_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int unsigned DW = $clog2(MAX_NODES + 1);

  // effective node count, already clamped to MAX_NODES
  logic [DW-1:0] n_active;

  dscc_cfg #(.MAX_NODES(MAX_NODES)) u_cfg (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .n_o (n_active)
  );

  // Update/query sequencer and the DFS over the edge memory
  dscc_engine #(
    .MAX_NODES        (MAX_NODES),
    .EDGE_COUNT_WIDTH (EDGE_COUNT_WIDTH)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .n_i         (n_active),
    .in_valid_i,
    .in_stall_o,
    .in_data_i,
    .out_valid_o,
    .out_stall_i,
    .out_data_o
  );

endmodule

`default_nettype wire
